// File: sv/charger_power_sequencer_assert.svh
// Assertion macros used by the charger power sequencer checker.
`ifndef CHARGER_POWER_SEQUENCER_ASSERT_SVH
`define CHARGER_POWER_SEQUENCER_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CPS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("charger power sequencer assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("charger power sequencer assertion failed");

// Next-cycle implication that is checked through reset as well.
`define CPS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("charger power sequencer assertion failed");

`endif

// File: sv/cps_pkg.sv
// Types, codes and helper functions of the charger power sequencer.
package cps_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SHORT_DELAY   = 2'd0;
   localparam logic [1:0] CSR_LONG_DELAY    = 2'd1;
   localparam logic [1:0] CSR_CURRENT_LIMIT = 2'd2;

   // Register reset values.
   localparam logic [15:0] SHORT_DELAY_RESET   = 16'd1000;
   localparam logic [15:0] LONG_DELAY_RESET    = 16'd2000;
   localparam logic [15:0] CURRENT_LIMIT_RESET = 16'd1000;

   // Relay and fan command codes.
   localparam logic [1:0] CMD_NONE = 2'd0;
   localparam logic [1:0] CMD_ON   = 2'd1;
   localparam logic [1:0] CMD_OFF  = 2'd2;

   // Battery manager link codes.
   localparam logic [1:0] LINK_ON_CHARGER  = 2'd1;
   localparam logic [1:0] LINK_OFF_CHARGER = 2'd2;

   // Mode codes as they appear on the result channel.
   localparam logic [2:0] MODE_CODE_INIT  = 3'd0;
   localparam logic [2:0] MODE_CODE_IDLE  = 3'd1;
   localparam logic [2:0] MODE_CODE_START = 3'd2;
   localparam logic [2:0] MODE_CODE_RUN   = 3'd3;
   localparam logic [2:0] MODE_CODE_FAULT = 3'd4;

   // Sequencer state, one-hot.
   typedef enum logic [4:0] {
      MODE_INIT  = 5'b00001,
      MODE_IDLE  = 5'b00010,
      MODE_START = 5'b00100,
      MODE_RUN   = 5'b01000,
      MODE_FAULT = 5'b10000
   } mode_type;

   // Configuration registers.
   typedef struct packed {
      logic [15:0] short_delay_ticks;
      logic [15:0] long_delay_ticks;
      logic [15:0] current_release_limit;
   } cfg_type;

   // One tick of input.
   typedef struct packed {
      logic        ac_undervolt_fault;
      logic        battery_undervolt_fault;
      logic        overtemp_fault;
      logic        any_alarm;
      logic [1:0]  link_status;
      logic [15:0] output_current_avg;
   } in_item_type;

   // One result of a tick.
   typedef struct packed {
      logic [2:0] mode;
      logic [1:0] ac_relay_cmd;
      logic [1:0] dc_relay_cmd;
      logic [1:0] fan_cmd;
      logic       pwm_zero;
      logic       run_refs;
      logic       system_reinit;
   } rsp_item_type;

   // Increment that sticks at the top of the 16-bit range.
   function automatic logic [15:0] sat_inc(input logic [15:0] value);
      sat_inc = (value == 16'hFFFF) ? value : value + 16'd1;
   endfunction

   // Mode code for the result channel.
   function automatic logic [2:0] mode_code(input mode_type mode);
      case (mode)
         MODE_INIT:  mode_code = MODE_CODE_INIT;
         MODE_IDLE:  mode_code = MODE_CODE_IDLE;
         MODE_START: mode_code = MODE_CODE_START;
         MODE_RUN:   mode_code = MODE_CODE_RUN;
         MODE_FAULT: mode_code = MODE_CODE_FAULT;
         default:    mode_code = MODE_CODE_INIT;
      endcase
   endfunction

endpackage

// File: sv/cps_csr.sv
// Configuration registers of the charger power sequencer.
module cps_csr (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_we,
   input  logic [1:0]      csr_index,
   input  logic [15:0]     csr_wdata,
   output cps_pkg::cfg_type cfg
);

   cps_pkg::cfg_type cfg_ff;
   cps_pkg::cfg_type cfg_in;

   // Decode the write; an index beyond the list leaves every register alone.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            cps_pkg::CSR_SHORT_DELAY:   cfg_in.short_delay_ticks     = csr_wdata;
            cps_pkg::CSR_LONG_DELAY:    cfg_in.long_delay_ticks      = csr_wdata;
            cps_pkg::CSR_CURRENT_LIMIT: cfg_in.current_release_limit = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_delay_ticks     <= cps_pkg::SHORT_DELAY_RESET;
         cfg_ff.long_delay_ticks      <= cps_pkg::LONG_DELAY_RESET;
         cfg_ff.current_release_limit <= cps_pkg::CURRENT_LIMIT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: sv/cps_in_reg.sv
// Input register stage that holds one tick until the sequencer takes it.
module cps_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  cps_pkg::in_item_type in_item,
   output logic                 in_ready,
   input  logic                 advance,
   output logic                 hold_valid,
   output cps_pkg::in_item_type hold_item
);

   logic                 valid_ff;
   logic                 valid_in;
   cps_pkg::in_item_type item_ff;
   logic                 load;

   // The stage takes a new transaction when empty or when its item moves on.
   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_item  = item_ff;

endmodule

// File: sv/cps_sequencer.sv
// Mode sequencer: state registers and the per-tick step logic.
module cps_sequencer (
   input  logic                  clock,
   input  logic                  reset,
   input  cps_pkg::cfg_type      cfg,
   input  logic                  step_en,
   input  cps_pkg::in_item_type  item,
   output cps_pkg::rsp_item_type result
);

   cps_pkg::mode_type mode_ff;
   cps_pkg::mode_type mode_in;
   logic [15:0]       delay_ff;
   logic [15:0]       delay_in;
   logic [15:0]       fault_ff;
   logic [15:0]       fault_in;
   logic [15:0]       delay_inc;
   logic [15:0]       fault_inc;
   logic              current_low;

   assign delay_inc   = cps_pkg::sat_inc(delay_ff);
   assign fault_inc   = cps_pkg::sat_inc(fault_ff);
   assign current_low = item.output_current_avg < cfg.current_release_limit;

   // Next state and commands for one tick.
   always_comb begin
      mode_in  = mode_ff;
      delay_in = delay_ff;
      fault_in = fault_ff;
      result.ac_relay_cmd  = cps_pkg::CMD_NONE;
      result.dc_relay_cmd  = cps_pkg::CMD_NONE;
      result.fan_cmd       = cps_pkg::CMD_NONE;
      result.pwm_zero      = 1'b0;
      result.run_refs      = 1'b0;
      result.system_reinit = 1'b0;
      case (mode_ff)
         cps_pkg::MODE_INIT: begin
            result.pwm_zero = 1'b1;
            delay_in = delay_inc;
            if (delay_inc >= cfg.short_delay_ticks) begin
               delay_in = 16'd0;
               mode_in  = cps_pkg::MODE_IDLE;
            end
         end
         cps_pkg::MODE_IDLE: begin
            if (!item.ac_undervolt_fault) begin
               result.ac_relay_cmd = cps_pkg::CMD_ON;
               delay_in = 16'd0;
               mode_in  = cps_pkg::MODE_START;
            end else begin
               result.ac_relay_cmd = cps_pkg::CMD_OFF;
            end
         end
         cps_pkg::MODE_START: begin
            // Wait for the battery manager, then count an alarm-free delay.
            if (item.link_status == cps_pkg::LINK_ON_CHARGER) begin
               if (!item.any_alarm) begin
                  delay_in = delay_inc;
                  if (delay_inc >= cfg.long_delay_ticks) begin
                     delay_in = 16'd0;
                     result.dc_relay_cmd = cps_pkg::CMD_ON;
                     mode_in = cps_pkg::MODE_RUN;
                  end
               end else begin
                  delay_in = 16'd0;
                  fault_in = 16'd0;
                  mode_in  = cps_pkg::MODE_FAULT;
               end
            end
         end
         cps_pkg::MODE_RUN: begin
            if (!item.any_alarm) begin
               result.run_refs = 1'b1;
               result.fan_cmd  = cps_pkg::CMD_ON;
            end
            if (item.any_alarm || item.link_status == cps_pkg::LINK_OFF_CHARGER) begin
               delay_in = 16'd0;
               fault_in = 16'd0;
               mode_in  = cps_pkg::MODE_FAULT;
            end
         end
         cps_pkg::MODE_FAULT: begin
            result.pwm_zero = 1'b1;
            result.fan_cmd  = item.overtemp_fault ? cps_pkg::CMD_ON : cps_pkg::CMD_OFF;
            fault_in = fault_inc;
            // After the short delay the relays may open at low current.
            if (fault_inc >= cfg.short_delay_ticks) begin
               if (item.battery_undervolt_fault && current_low) begin
                  result.dc_relay_cmd = cps_pkg::CMD_OFF;
               end
               if (item.ac_undervolt_fault && current_low) begin
                  result.ac_relay_cmd = cps_pkg::CMD_OFF;
               end
               fault_in = cfg.short_delay_ticks;
            end
            // Recovery after a long alarm-free delay.
            if (!item.any_alarm) begin
               delay_in = delay_inc;
               if (delay_inc >= cfg.long_delay_ticks) begin
                  fault_in = 16'd0;
                  delay_in = 16'd0;
                  result.system_reinit = 1'b1;
                  mode_in = cps_pkg::MODE_IDLE;
               end
            end
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
      result.mode = cps_pkg::mode_code(mode_in);
   end

   // State moves only when a tick is handed to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= cps_pkg::MODE_INIT;
         delay_ff <= 16'd0;
         fault_ff <= 16'd0;
      end else if (step_en) begin
         mode_ff  <= mode_in;
         delay_ff <= delay_in;
         fault_ff <= fault_in;
      end
   end

endmodule

// File: sv/charger_power_sequencer.sv
// Top level of the charger power sequencer.
//
//   channel   direction  handshake              payload
//   req_      in         req_tvalid/req_tready  req_tdata, one tick of alarms and current
//   rsp_      out        rsp_tvalid/rsp_tready  rsp_tdata, mode and commands of the tick
//   csr_      in         csr_we                 csr_index, csr_wdata
//
// A tick is registered in the input stage on acceptance and its result in the result register,
// and one tick is taken every cycle while results are taken without a stall.
// The mode, delay and fault counters move when a tick passes into the result register.
// Reset is synchronous and active high; it returns the mode to init and the
// registers to their defaults.
// A stalled result holds the input stage; both stages free up in the cycle the
// result is taken.
module charger_power_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] ac_undervolt_fault, [1] battery_undervolt_fault, [2] overtemp_fault,
   // [3] any_alarm, [5:4] link_status, [21:6] output_current_avg, [23:22] zero
   input  logic [23:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] mode, [4:3] ac_relay_cmd, [6:5] dc_relay_cmd, [8:7] fan_cmd,
   // [9] pwm_zero, [10] run_refs, [11] system_reinit, [15:12] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cps_pkg::cfg_type      cfg;
   cps_pkg::in_item_type  req_item;
   cps_pkg::in_item_type  hold_item;
   cps_pkg::rsp_item_type step_result;
   cps_pkg::rsp_item_type rsp_item_ff;
   logic                  hold_valid;
   logic                  advance;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;

   // Unpack the request payload.
   assign req_item.ac_undervolt_fault      = req_tdata[0];
   assign req_item.battery_undervolt_fault = req_tdata[1];
   assign req_item.overtemp_fault          = req_tdata[2];
   assign req_item.any_alarm               = req_tdata[3];
   assign req_item.link_status             = req_tdata[5:4];
   assign req_item.output_current_avg      = req_tdata[21:6];

   cps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // A held tick moves on when the result register is empty or being drained.
   assign advance = hold_valid && (!rsp_valid_ff || rsp_tready);

   cps_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_item    (req_item),
      .in_ready   (req_tready),
      .advance    (advance),
      .hold_valid (hold_valid),
      .hold_item  (hold_item)
   );

   cps_sequencer u_sequencer (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .step_en (advance),
      .item    (hold_item),
      .result  (step_result)
   );

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= step_result;
      end
   end

   // Pack the response payload.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0000,
                        rsp_item_ff.system_reinit,
                        rsp_item_ff.run_refs,
                        rsp_item_ff.pwm_zero,
                        rsp_item_ff.fan_cmd,
                        rsp_item_ff.dc_relay_cmd,
                        rsp_item_ff.ac_relay_cmd,
                        rsp_item_ff.mode};

endmodule

// File: sv/cps_checker.sv
// Port-level checks of the charger power sequencer and their binding.
`include "charger_power_sequencer_assert.svh"

module cps_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata
);

   // A stalled result keeps its value.
   `CPS_ASSERT_NEXT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // No result is offered right after reset.
   `CPS_ASSERT_NEXT_ALWAYS(rsp_reset_a, clock, reset, !rsp_tvalid)

   // A reinit pulse comes only from fault recovery, which lands in idle with duties zeroed.
   `CPS_ASSERT_IMPL(reinit_mode_a, clock, reset, rsp_tvalid && rsp_tdata[11], rsp_tdata[2:0] == cps_pkg::MODE_CODE_IDLE && rsp_tdata[9])

   // Run references are loaded only on a run tick, which may end in fault.
   `CPS_ASSERT_IMPL(run_refs_mode_a, clock, reset, rsp_tvalid && rsp_tdata[10], rsp_tdata[2:0] == cps_pkg::MODE_CODE_RUN || rsp_tdata[2:0] == cps_pkg::MODE_CODE_FAULT)

   // Zeroed duties never appear together with loaded run references, nor with a start or run mode.
   `CPS_ASSERT_IMPL(pwm_refs_a, clock, reset, rsp_tvalid && rsp_tdata[9], !rsp_tdata[10] && rsp_tdata[2:0] != cps_pkg::MODE_CODE_START && rsp_tdata[2:0] != cps_pkg::MODE_CODE_RUN)

endmodule

bind charger_power_sequencer cps_checker u_cps_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
